[rtl/core/hrcp_pkg.sv]
// Shared types, widths and register codes for the heading/roll cascade PID.
package hrcp_pkg;

    // Field and datapath widths
    localparam int ANG_W    = 16;                 // Q3.12 angle fields
    localparam int GAIN_W   = 16;                 // Q8.8 gains and Q0.16 time step
    localparam int CFG_W    = 16;                 // widest configuration register
    localparam int IDX_W    = 3;                  // configuration register index
    localparam int PULSE_W  = 12;                 // servo pulse width in us
    localparam int RERR_W   = ANG_W + 1;          // roll error
    localparam int DIFF_W   = RERR_W + 1;         // change of roll error
    localparam int NUM_W    = DIFF_W + GAIN_W;    // |diff| * 65536 for the divider
    localparam int AW       = NUM_W;              // signed multiplier operand A
    localparam int BW       = GAIN_W;             // unsigned multiplier operand B
    localparam int PW       = AW + BW + 1;        // full signed product
    localparam int IW       = 32;                 // error integral
    localparam int SW       = IW + 2;             // integral sum before saturation
    localparam int PT_W     = 25;                 // proportional term
    localparam int IT_W     = 16;                 // clamped integral term
    localparam int PIS_W    = PT_W + 1;           // proportional plus integral
    localparam int TW       = 43;                 // sum of all three terms
    localparam int OFF_W    = 11;                 // clamped servo offset
    localparam int SUM_W    = PULSE_W + 2;        // centre plus offset
    localparam int CNT_SHIFT_MAX = 16;            // largest fixed rescale shift

    // Servo scaling from Q-format to microseconds
    localparam logic [BW-1:0] OUTPUT_SCALE = 16'd500;

    // Saturation bounds of the error integral
    localparam logic signed [SW-1:0] EI_MAX = {{(SW-IW+1){1'b0}}, {(IW-1){1'b1}}};
    localparam logic signed [SW-1:0] EI_MIN = {{(SW-IW+1){1'b1}}, {(IW-1){1'b0}}};

    // Largest pulse width
    localparam logic signed [SUM_W-1:0] PULSE_MAX = SUM_W'(4095);

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_HEADING_GAIN     = 3'd0,
        REG_BANK_LIMIT       = 3'd1,
        REG_PROP_GAIN        = 3'd2,
        REG_INTEG_GAIN       = 3'd3,
        REG_DERIV_GAIN       = 3'd4,
        REG_INTEG_TERM_LIMIT = 3'd5,
        REG_TRIM_LIMIT       = 3'd6,
        REG_CENTER_WIDTH     = 3'd7
    } t_reg_idx;

    // Configuration register set
    typedef struct packed {
        logic [15:0] heading_gain;
        logic [14:0] bank_limit;
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] deriv_gain;
        logic [14:0] integ_term_limit;
        logic [9:0]  trim_limit;
        logic [11:0] center_width;
    } t_cfg;

    // Rescale applied after a multiplication
    typedef enum logic [1:0] {
        SH_BYTE,
        SH_WORD,
        SH_FRAC
    } t_shift;

    // Request to the shared multiplier
    typedef struct packed {
        logic   start;
        t_shift shift;
    } t_mul_req;

    // Request to the serial divider
    typedef struct packed {
        logic start;
        logic neg;
    } t_div_req;

endpackage

[rtl/core/heading_roll_cascade_pid.sv]
// Heading-to-roll cascaded PID controller: sequencer, state and output register.
//
// One request produces one servo pulse width. A normal control step first wraps the
// heading error into plus or minus pi where needed. Most of a normal step is spent
// in the 34-step serial divider that forms the derivative, which runs alongside the
// integral multiplies on the one shared multiplier. A clear request or a zero time
// step skips the cascade and hands the centre width straight to the output register.
// The input side stalls while a step is in progress, and while a result waits
// for a full output register; a finished pulse width waits in the output
// register, and a new request is taken meanwhile. Configuration writes take
// effect at once and are meant for when the block is idle.
module heading_roll_cascade_pid #(
    parameter int ANGLE_FRAC_BITS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic signed [15:0] i_target_heading,
    input  logic signed [15:0] i_current_heading,
    input  logic signed [15:0] i_current_roll,
    input  logic        [15:0] i_time_step,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic        [11:0] o_pulse_width,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic        [2:0]  i_cfg_index,
    input  logic        [15:0] i_cfg_data
);
    import hrcp_pkg::*;

    // pi rounded to the angle format, and the heading error width it needs
    localparam logic [63:0] PI_U =
        ((64'd3141592653590 << ANGLE_FRAC_BITS) + 64'd500000000000) / 64'd1000000000000;
    localparam int HW_PI = $clog2(2 * PI_U + 1) + 1;
    localparam int HW    = (HW_PI > RERR_W) ? HW_PI : RERR_W;
    localparam logic signed [HW-1:0] PI_H     = HW'(PI_U);
    localparam logic signed [HW-1:0] NEG_PI_H = -PI_H;
    localparam logic signed [HW-1:0] TWO_PI_H = HW'(2 * PI_U);

    // Total is limited before scaling to a span that still saturates the offset
    localparam int CW = ANGLE_FRAC_BITS + 12;
    localparam logic signed [TW-1:0] TOTAL_LIM     = TW'(1024) << ANGLE_FRAC_BITS;
    localparam logic signed [TW-1:0] NEG_TOTAL_LIM = -TOTAL_LIM;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRAP,
        S_MUL,
        S_RERR,
        S_DIFF,
        S_ITERM,
        S_DWAIT,
        S_TCLAMP,
        S_SCALE,
        S_PULSE,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        OP_HEAD,
        OP_PROP,
        OP_INC,
        OP_ITERM,
        OP_DERIV,
        OP_OUT
    } t_op;

    t_cfg                     cfg;

    t_state                   r_state;
    t_op                      r_op;
    logic signed [ANG_W-1:0]  r_roll;
    logic        [GAIN_W-1:0] r_dt;
    logic signed [HW-1:0]     r_herr;
    logic signed [ANG_W-1:0]  r_troll;
    logic signed [RERR_W-1:0] r_rerr;
    logic signed [RERR_W-1:0] r_prev;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [IW-1:0]     r_ei;
    logic signed [PT_W-1:0]   r_pterm;
    logic signed [IT_W-1:0]   r_iterm;
    logic signed [PIS_W-1:0]  r_pi;
    logic signed [TW-1:0]     r_total;
    logic signed [CW-1:0]     r_totc;
    logic signed [OFF_W-1:0]  r_offset;
    logic [PULSE_W-1:0]       r_result;
    logic [PULSE_W-1:0]       r_out_pw;
    logic                     r_out_valid;

    t_mul_req                 r_mul_req;
    logic signed [AW-1:0]     r_mul_a;
    logic [BW-1:0]            r_mul_b;
    logic                     mul_done;
    logic signed [PW-1:0]     mul_res;

    t_div_req                 r_div_req;
    logic [NUM_W-1:0]         r_div_num;
    logic                     div_done;
    logic signed [AW-1:0]     div_quot;

    logic signed [SW-1:0]     ei_sum;
    logic signed [IW-1:0]     ei_sat;
    logic [DIFF_W-1:0]        abs_diff;
    logic signed [SUM_W-1:0]  pulse_sum;
    logic [PULSE_W-1:0]       pulse_sat;

    // Limit a product to plus or minus an unsigned bound
    function automatic logic signed [PW-1:0] clamp_sym(input logic signed [PW-1:0] v,
                                                       input logic [15:0] lim);
        logic signed [PW-1:0] hi;
        hi = signed'(PW'(lim));
        if (v > hi) begin
            return hi;
        end else if (v < -hi) begin
            return -hi;
        end else begin
            return v;
        end
    endfunction

    hrcp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    hrcp_mul_unit #(
        .FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mul_req),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    hrcp_div_unit u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .i_num   (r_div_num),
        .i_den   (r_dt),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Integral saturation, divider magnitude and final pulse range
    always_comb begin
        ei_sum = SW'(r_ei) + SW'(mul_res);
        if (ei_sum > EI_MAX) begin
            ei_sat = IW'(EI_MAX);
        end else if (ei_sum < EI_MIN) begin
            ei_sat = IW'(EI_MIN);
        end else begin
            ei_sat = IW'(ei_sum);
        end
        abs_diff  = r_diff[DIFF_W-1] ? DIFF_W'(-r_diff) : DIFF_W'(r_diff);
        pulse_sum = signed'({2'b00, cfg.center_width}) + SUM_W'(r_offset);
        if (pulse_sum < 0) begin
            pulse_sat = '0;
        end else if (pulse_sum > PULSE_MAX) begin
            pulse_sat = PULSE_W'(PULSE_MAX);
        end else begin
            pulse_sat = PULSE_W'(pulse_sum);
        end
    end

    // Sequencer, controller state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_op          <= OP_HEAD;
            r_ei          <= '0;
            r_prev        <= '0;
            r_out_valid   <= 1'b0;
            r_mul_req     <= '{start: 1'b0, shift: SH_BYTE};
            r_div_req     <= '{start: 1'b0, neg: 1'b0};
        end else begin
            r_mul_req.start <= 1'b0;
            r_div_req.start <= 1'b0;

            // Drop the result once taken
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_roll <= i_current_roll;
                        r_dt   <= i_time_step;
                        r_herr <= HW'(i_target_heading) - HW'(i_current_heading);
                        if (i_action) begin
                            r_ei     <= '0;
                            r_prev   <= '0;
                            r_result <= cfg.center_width;
                            r_state  <= S_FIN;
                        end else if (i_time_step == '0) begin
                            r_result <= cfg.center_width;
                            r_state  <= S_FIN;
                        end else begin
                            r_state <= S_WRAP;
                        end
                    end
                end

                // Wrap heading error into plus or minus pi, then scale to roll demand
                S_WRAP: begin
                    if (r_herr > PI_H) begin
                        r_herr <= r_herr - TWO_PI_H;
                    end else if (r_herr < NEG_PI_H) begin
                        r_herr <= r_herr + TWO_PI_H;
                    end else begin
                        r_mul_a   <= AW'(r_herr);
                        r_mul_b   <= cfg.heading_gain;
                        r_mul_req <= '{start: 1'b1, shift: SH_BYTE};
                        r_op      <= OP_HEAD;
                        r_state   <= S_MUL;
                    end
                end

                // Take each product as it completes and issue the next one
                S_MUL: begin
                    if (mul_done) begin
                        unique case (r_op)
                            OP_HEAD: begin
                                r_troll <= ANG_W'(clamp_sym(mul_res, 16'(cfg.bank_limit)));
                                r_state <= S_RERR;
                            end
                            OP_PROP: begin
                                r_pterm   <= PT_W'(mul_res);
                                r_div_num <= {abs_diff, {GAIN_W{1'b0}}};
                                r_div_req <= '{start: 1'b1, neg: r_diff[DIFF_W-1]};
                                r_mul_a   <= AW'(r_rerr);
                                r_mul_b   <= r_dt;
                                r_mul_req <= '{start: 1'b1, shift: SH_WORD};
                                r_op      <= OP_INC;
                            end
                            OP_INC: begin
                                r_ei    <= ei_sat;
                                r_state <= S_ITERM;
                            end
                            OP_ITERM: begin
                                r_iterm <= IT_W'(clamp_sym(mul_res,
                                                           16'(cfg.integ_term_limit)));
                                r_state <= S_DWAIT;
                            end
                            OP_DERIV: begin
                                r_total <= TW'(r_pi) + TW'(mul_res);
                                r_state <= S_TCLAMP;
                            end
                            OP_OUT: begin
                                r_offset <= OFF_W'(clamp_sym(mul_res, 16'(cfg.trim_limit)));
                                r_state  <= S_PULSE;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_RERR: begin
                    r_rerr  <= RERR_W'(r_troll) - RERR_W'(r_roll);
                    r_state <= S_DIFF;
                end

                // Form the error change, advance the stored error, start proportional term
                S_DIFF: begin
                    r_diff    <= DIFF_W'(r_rerr) - DIFF_W'(r_prev);
                    r_prev    <= r_rerr;
                    r_mul_a   <= AW'(r_rerr);
                    r_mul_b   <= cfg.prop_gain;
                    r_mul_req <= '{start: 1'b1, shift: SH_BYTE};
                    r_op      <= OP_PROP;
                    r_state   <= S_MUL;
                end

                S_ITERM: begin
                    r_mul_a   <= AW'(r_ei);
                    r_mul_b   <= cfg.integ_gain;
                    r_mul_req <= '{start: 1'b1, shift: SH_BYTE};
                    r_op      <= OP_ITERM;
                    r_state   <= S_MUL;
                end

                // Hold until the error rate is ready, then scale it
                S_DWAIT: begin
                    r_pi <= PIS_W'(r_pterm) + PIS_W'(r_iterm);
                    if (div_done) begin
                        r_mul_a   <= div_quot;
                        r_mul_b   <= cfg.deriv_gain;
                        r_mul_req <= '{start: 1'b1, shift: SH_BYTE};
                        r_op      <= OP_DERIV;
                        r_state   <= S_MUL;
                    end
                end

                S_TCLAMP: begin
                    if (r_total > TOTAL_LIM) begin
                        r_totc <= CW'(TOTAL_LIM);
                    end else if (r_total < NEG_TOTAL_LIM) begin
                        r_totc <= CW'(NEG_TOTAL_LIM);
                    end else begin
                        r_totc <= CW'(r_total);
                    end
                    r_state <= S_SCALE;
                end

                S_SCALE: begin
                    r_mul_a   <= AW'(r_totc);
                    r_mul_b   <= OUTPUT_SCALE;
                    r_mul_req <= '{start: 1'b1, shift: SH_FRAC};
                    r_op      <= OP_OUT;
                    r_state   <= S_MUL;
                end

                S_PULSE: begin
                    r_result <= pulse_sat;
                    r_state  <= S_FIN;
                end

                // Hand the result over once the output register is free
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_pw    <= r_result;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_pulse_width = r_out_pw;

endmodule

[rtl/core/hrcp_cfg_regs.sv]
// Configuration register file of the heading/roll cascade PID.
module hrcp_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [hrcp_pkg::IDX_W-1:0]   i_index,
    input  logic [hrcp_pkg::CFG_W-1:0]   i_data,
    output hrcp_pkg::t_cfg               o_cfg
);
    import hrcp_pkg::*;

    t_cfg r_cfg;

    // Write one register; drop the bits above its width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heading_gain     <= 16'd256;
            r_cfg.bank_limit       <= 15'd2048;
            r_cfg.prop_gain        <= 16'd256;
            r_cfg.integ_gain       <= 16'd0;
            r_cfg.deriv_gain       <= 16'd0;
            r_cfg.integ_term_limit <= 15'd4096;
            r_cfg.trim_limit       <= 10'd500;
            r_cfg.center_width     <= 12'd1500;
        end else if (i_we) begin
            unique case (t_reg_idx'(i_index))
                REG_HEADING_GAIN:     r_cfg.heading_gain     <= i_data;
                REG_BANK_LIMIT:       r_cfg.bank_limit       <= i_data[14:0];
                REG_PROP_GAIN:        r_cfg.prop_gain        <= i_data;
                REG_INTEG_GAIN:       r_cfg.integ_gain       <= i_data;
                REG_DERIV_GAIN:       r_cfg.deriv_gain       <= i_data;
                REG_INTEG_TERM_LIMIT: r_cfg.integ_term_limit <= i_data[14:0];
                REG_TRIM_LIMIT:       r_cfg.trim_limit       <= i_data[9:0];
                REG_CENTER_WIDTH:     r_cfg.center_width     <= i_data[11:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/hrcp_mul_unit.sv]
// Shared signed-by-unsigned multiplier with a truncate-toward-zero rescale.
module hrcp_mul_unit #(
    parameter int FRAC_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  hrcp_pkg::t_mul_req                 i_req,
    input  logic signed [hrcp_pkg::AW-1:0]     i_a,
    input  logic        [hrcp_pkg::BW-1:0]     i_b,
    output logic                               o_done,
    output logic signed [hrcp_pkg::PW-1:0]     o_res
);
    import hrcp_pkg::*;

    localparam int MAX_SH = (FRAC_BITS > CNT_SHIFT_MAX) ? FRAC_BITS : CNT_SHIFT_MAX;
    localparam int AMT_W  = $clog2(MAX_SH + 1);

    logic signed [PW-1:0] r_prod;
    t_shift               r_shift;
    logic                 r_prod_vld;
    logic signed [PW-1:0] r_res;
    logic                 r_done;

    logic signed [BW:0]   b_ext;
    logic [AMT_W-1:0]     amt;
    logic signed [PW-1:0] bias;
    logic signed [PW-1:0] scaled;

    assign b_ext = {1'b0, i_b};

    // Pick the rescale and bias negative products so the shift truncates toward zero
    always_comb begin
        case (r_shift)
            SH_BYTE: amt = AMT_W'(8);
            SH_WORD: amt = AMT_W'(16);
            SH_FRAC: amt = AMT_W'(FRAC_BITS);
            default: amt = AMT_W'(8);
        endcase
        bias   = r_prod[PW-1] ? ((PW'(1) << amt) - PW'(1)) : '0;
        scaled = (r_prod + bias) >>> amt;
    end

    // Stage one: product; stage two: rescaled result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_prod_vld <= i_req.start;
            r_done     <= r_prod_vld;
        end
        if (i_req.start) begin
            r_prod  <= i_a * b_ext;
            r_shift <= i_req.shift;
        end
        if (r_prod_vld) begin
            r_res <= scaled;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[rtl/core/hrcp_div_unit.sv]
// Restoring serial divider, one quotient bit per cycle, with sign fix-up.
module hrcp_div_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  hrcp_pkg::t_div_req                 i_req,
    input  logic        [hrcp_pkg::NUM_W-1:0]  i_num,
    input  logic        [hrcp_pkg::GAIN_W-1:0] i_den,
    output logic                               o_done,
    output logic signed [hrcp_pkg::AW-1:0]     o_quot
);
    import hrcp_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_SIGN
    } t_div_state;

    t_div_state           r_state;
    logic [NUM_W-1:0]     r_num;
    logic [GAIN_W-1:0]    r_den;
    logic [GAIN_W-1:0]    r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_neg;
    logic                 r_done;
    logic signed [AW-1:0] r_quot;

    logic [GAIN_W:0]      trial;
    logic [GAIN_W:0]      diff;
    logic                 qbit;

    // Bring down the next numerator bit and try the subtraction
    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
    end

    // Sequence the division; hold the result and done until the next request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else if (i_req.start) begin
            r_num   <= i_num;
            r_den   <= i_den;
            r_rem   <= '0;
            r_neg   <= i_req.neg;
            r_cnt   <= CNT_W'(NUM_W);
            r_done  <= 1'b0;
            r_state <= D_RUN;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    r_done <= r_done;
                end
                D_RUN: begin
                    r_rem <= qbit ? diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
                    r_num <= {r_num[NUM_W-2:0], qbit};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= D_SIGN;
                    end
                end
                D_SIGN: begin
                    r_quot  <= r_neg ? -signed'(r_num) : signed'(r_num);
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
